FILE: rtl/glyph_quad_generator_defines.svh
// Assertion macros used by the glyph quad generator RTL (the emit stage).
`ifndef GLYPH_QUAD_GENERATOR_DEFINES_SVH
`define GLYPH_QUAD_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define GQG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gqg: same-cycle check failed");
`define GQG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gqg: next-cycle check failed");
`else
`define GQG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GQG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/gqg_pkg.sv
// Types and constants shared by the glyph quad generator.
`default_nettype none
package gqg_pkg;

  localparam int COORD_W     = 20;
  localparam int CODE_W      = 21;
  localparam int OFFSET_W    = 12;
  localparam int SIZE_W      = 10;
  localparam int TEX_W       = 16;
  localparam int NUMBER_W    = 16;
  localparam int ORIGIN_W    = 16;
  localparam int SPACING_W   = 10;
  localparam int SCALE_W     = 16;
  localparam int SCALE_FRAC  = 12;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 20;
  localparam int PROD_W      = OFFSET_W + SCALE_W + 1;

  localparam logic [CODE_W-1:0] CODE_NEWLINE = 21'd10;
  localparam logic [CODE_W-1:0] CODE_RETURN  = 21'd13;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sh7FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 20'sh80000;

  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_SPACING = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_SCALE  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LEFT    = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_TOP     = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_RIGHT   = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_BOTTOM  = 4'd7;

  typedef enum logic [1:0] {
    CORNER_PEN      = 2'd0,
    CORNER_UP       = 2'd1,
    CORNER_UP_RIGHT = 2'd2,
    CORNER_RIGHT    = 2'd3
  } corner_t;

  typedef struct packed {
    logic [CODE_W-1:0]          code_point;
    logic signed [OFFSET_W-1:0] offset_x;
    logic signed [OFFSET_W-1:0] offset_y;
    logic [SIZE_W-1:0]          glyph_width;
    logic [SIZE_W-1:0]          glyph_height;
    logic [SIZE_W-1:0]          advance;
    logic [TEX_W-1:0]           tex_u0;
    logic [TEX_W-1:0]           tex_v0;
    logic [TEX_W-1:0]           tex_u1;
    logic [TEX_W-1:0]           tex_v1;
    logic                       last_glyph;
  } glyph_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic [TEX_W-1:0]          vertex_u;
    logic [TEX_W-1:0]          vertex_v;
    logic [NUMBER_W-1:0]       vertex_number;
    logic [1:0]                corner;
    logic                      quad_done;
  } vertex_t;

  typedef struct packed {
    logic newline;
    logic carriage;
    logic last;
  } item_ctl_t;

  typedef struct packed {
    logic [TEX_W-1:0] u0;
    logic [TEX_W-1:0] v0;
    logic [TEX_W-1:0] u1;
    logic [TEX_W-1:0] v1;
  } tex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] y1;
    tex_t                      tex;
  } quad_t;

  typedef struct packed {
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic [SPACING_W-1:0]       line_spacing;
    logic [SCALE_W-1:0]         glyph_scale;
    logic signed [COORD_W-1:0]  clip_left;
    logic signed [COORD_W-1:0]  clip_top;
    logic signed [COORD_W-1:0]  clip_right;
    logic signed [COORD_W-1:0]  clip_bottom;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/gqg_channels.sv
// Handshake channel interfaces for glyphs, vertices and register writes.
`default_nettype none
interface gqg_glyph_if import gqg_pkg::*; ();
  logic   valid;
  logic   ready;
  glyph_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gqg_vertex_if import gqg_pkg::*; ();
  logic    valid;
  logic    ready;
  vertex_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gqg_cfg_if import gqg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/gqg_scale.sv
// Scaling stage: converts glyph metrics from font pixels to subpixel units.
`default_nettype none
module gqg_scale import gqg_pkg::*; #(
  parameter int SUBPIXEL_BITS = 4,
  localparam int SHIFT = SCALE_FRAC - SUBPIXEL_BITS,
  localparam int SCALED_W = PROD_W - SHIFT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [SCALE_W-1:0]         glyph_scale,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  glyph_t                     glyph,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic signed [SCALED_W-1:0] off_x,
  output logic signed [SCALED_W-1:0] off_y,
  output logic signed [SCALED_W-1:0] size_x,
  output logic signed [SCALED_W-1:0] size_y,
  output logic signed [SCALED_W-1:0] adv,
  output item_ctl_t                  ctl,
  output tex_t                       tex
);

  localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(64'd1 << (SHIFT - 1));

  logic signed [SCALE_W:0]        scale_s;
  logic signed [PROD_W-1:0]       p_ox, p_oy, p_sx, p_sy, p_adv;
  logic signed [PROD_W-1:0]       r_ox, r_oy, r_sx, r_sy, r_adv;
  logic                           valid_r, valid_nxt;
  logic signed [SCALED_W-1:0]     off_x_r, off_y_r, size_x_r, size_y_r, adv_r;
  item_ctl_t                      ctl_r, ctl_nxt;
  tex_t                           tex_r, tex_nxt;
  logic                           load;

  assign scale_s = $signed({1'b0, glyph_scale});
  assign p_ox  = glyph.offset_x * scale_s;
  assign p_oy  = glyph.offset_y * scale_s;
  assign p_sx  = $signed({1'b0, glyph.glyph_width}) * scale_s;
  assign p_sy  = $signed({1'b0, glyph.glyph_height}) * scale_s;
  assign p_adv = $signed({1'b0, glyph.advance}) * scale_s;

  // Round half up, then an arithmetic shift floors toward minus infinity.
  assign r_ox  = p_ox + ROUND;
  assign r_oy  = p_oy + ROUND;
  assign r_sx  = p_sx + ROUND;
  assign r_sy  = p_sy + ROUND;
  assign r_adv = p_adv + ROUND;

  assign ctl_nxt.newline  = (glyph.code_point == CODE_NEWLINE);
  assign ctl_nxt.carriage = (glyph.code_point == CODE_RETURN);
  assign ctl_nxt.last     = glyph.last_glyph;
  assign tex_nxt.u0       = glyph.tex_u0;
  assign tex_nxt.v0       = glyph.tex_v0;
  assign tex_nxt.u1       = glyph.tex_u1;
  assign tex_nxt.v1       = glyph.tex_v1;

  assign up_ready  = !valid_r || dn_ready;
  assign load      = up_valid && up_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      off_x_r  <= r_ox[PROD_W-1:SHIFT];
      off_y_r  <= r_oy[PROD_W-1:SHIFT];
      size_x_r <= r_sx[PROD_W-1:SHIFT];
      size_y_r <= r_sy[PROD_W-1:SHIFT];
      adv_r    <= r_adv[PROD_W-1:SHIFT];
      ctl_r    <= ctl_nxt;
      tex_r    <= tex_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign off_x    = off_x_r;
  assign off_y    = off_y_r;
  assign size_x   = size_x_r;
  assign size_y   = size_y_r;
  assign adv      = adv_r;
  assign ctl      = ctl_r;
  assign tex      = tex_r;

endmodule
`default_nettype wire

FILE: rtl/gqg_place.sv
// Placement stage: pen state, glyph box, scissor test and vertex counter.
`default_nettype none
module gqg_place import gqg_pkg::*; #(
  parameter int SUBPIXEL_BITS = 4,
  parameter int INDEX_BITS = 16,
  localparam int SCALED_W = PROD_W - (SCALE_FRAC - SUBPIXEL_BITS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic signed [SCALED_W-1:0] off_x,
  input  logic signed [SCALED_W-1:0] off_y,
  input  logic signed [SCALED_W-1:0] size_x,
  input  logic signed [SCALED_W-1:0] size_y,
  input  logic signed [SCALED_W-1:0] adv,
  input  item_ctl_t                  ctl,
  input  tex_t                       tex,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output quad_t                      quad,
  output logic [INDEX_BITS-1:0]      number_base
);

  localparam int WIDE_W = ((SCALED_W > COORD_W) ? SCALED_W : COORD_W) + 2;
  localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(COORD_MAX);
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = WIDE_W'(COORD_MIN);

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [COORD_W-1:0] r;
    if (v > WIDE_MAX) begin
      r = COORD_MAX;
    end else if (v < WIDE_MIN) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  logic signed [COORD_W-1:0]  pen_col_r, pen_col_nxt;
  logic signed [COORD_W-1:0]  pen_row_r, pen_row_nxt;
  logic                       restart_r, restart_nxt;
  logic [INDEX_BITS-1:0]      counter_r, counter_nxt;

  logic signed [WIDE_W-1:0]   origin_x_w, origin_y_w, spacing_w;
  logic signed [COORD_W-1:0]  origin_col, origin_row;
  logic signed [COORD_W-1:0]  pen_col_eff, pen_row_eff;
  logic signed [WIDE_W-1:0]   px, py, x1, y0;
  logic                       is_glyph, visible, fire;

  assign origin_x_w  = WIDE_W'(cfg.origin_x);
  assign origin_y_w  = WIDE_W'(cfg.origin_y);
  assign spacing_w   = WIDE_W'($signed({1'b0, cfg.line_spacing}));
  assign origin_col  = sat_coord(origin_x_w <<< SUBPIXEL_BITS);
  assign origin_row  = sat_coord(origin_y_w <<< SUBPIXEL_BITS);

  assign pen_col_eff = restart_r ? origin_col : pen_col_r;
  assign pen_row_eff = restart_r ? origin_row : pen_row_r;

  assign px = WIDE_W'(pen_col_eff) + WIDE_W'(off_x);
  assign py = WIDE_W'(pen_row_eff) + WIDE_W'(off_y);
  assign x1 = px + WIDE_W'(size_x);
  assign y0 = py - WIDE_W'(size_y);

  assign is_glyph = !ctl.newline && !ctl.carriage;
  assign visible  = is_glyph
                    && (px < WIDE_W'(cfg.clip_right)) && (x1 > WIDE_W'(cfg.clip_left))
                    && (y0 < WIDE_W'(cfg.clip_bottom)) && (py > WIDE_W'(cfg.clip_top));

  assign dn_valid = up_valid && visible;
  assign up_ready = !visible || dn_ready;
  assign fire     = up_valid && up_ready;

  always_comb begin
    pen_col_nxt = pen_col_r;
    pen_row_nxt = pen_row_r;
    restart_nxt = restart_r;
    counter_nxt = counter_r;
    if (fire) begin
      restart_nxt = ctl.last;
      if (ctl.newline) begin
        pen_col_nxt = origin_col;
        pen_row_nxt = sat_coord(WIDE_W'(pen_row_eff) + (spacing_w <<< SUBPIXEL_BITS));
      end else if (ctl.carriage) begin
        pen_col_nxt = pen_col_eff;
        pen_row_nxt = pen_row_eff;
      end else begin
        pen_col_nxt = sat_coord(WIDE_W'(pen_col_eff) + WIDE_W'(adv));
        pen_row_nxt = pen_row_eff;
        if (visible) begin
          counter_nxt = counter_r + INDEX_BITS'(4);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_col_r <= '0;
      pen_row_r <= '0;
      restart_r <= 1'b1;
      counter_r <= '0;
    end else begin
      pen_col_r <= pen_col_nxt;
      pen_row_r <= pen_row_nxt;
      restart_r <= restart_nxt;
      counter_r <= counter_nxt;
    end
  end

  assign quad.x0      = sat_coord(px);
  assign quad.x1      = sat_coord(x1);
  assign quad.y0      = sat_coord(y0);
  assign quad.y1      = sat_coord(py);
  assign quad.tex     = tex;
  assign number_base  = counter_r;

endmodule
`default_nettype wire

FILE: rtl/gqg_emit.sv
// Quad register and corner sequencer that sends four vertices per quad.
`default_nettype none
`include "glyph_quad_generator_defines.svh"
module gqg_emit import gqg_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  quad_t                 quad,
  input  logic [INDEX_BITS-1:0] number_base,
  gqg_vertex_if.source          out_vertex
);

  localparam int NUM_EXT_W = (INDEX_BITS > NUMBER_W) ? INDEX_BITS : NUMBER_W;

  logic                  quad_valid_r, quad_valid_nxt;
  quad_t                 quad_r;
  logic [INDEX_BITS-1:0] base_r;
  corner_t               corner_r, corner_nxt;
  logic                  load, xfer, last_xfer;
  logic [INDEX_BITS-1:0] num_w;
  logic [NUM_EXT_W-1:0]  num_ext;

  assign xfer      = quad_valid_r && out_vertex.ready;
  assign last_xfer = xfer && (corner_r == CORNER_RIGHT);
  assign up_ready  = !quad_valid_r || last_xfer;
  assign load      = up_valid && up_ready;

  always_comb begin
    quad_valid_nxt = quad_valid_r;
    corner_nxt     = corner_r;
    if (xfer) begin
      corner_nxt = corner_t'(corner_r + 2'd1);
    end
    if (load) begin
      quad_valid_nxt = 1'b1;
    end else if (last_xfer) begin
      quad_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_valid_r <= 1'b0;
      corner_r     <= CORNER_PEN;
    end else begin
      quad_valid_r <= quad_valid_nxt;
      corner_r     <= corner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quad_r <= quad;
      base_r <= number_base;
    end
  end

  assign num_w   = base_r + INDEX_BITS'(corner_r);
  assign num_ext = NUM_EXT_W'(num_w);

  always_comb begin
    out_vertex.data.vertex_number = num_ext[NUMBER_W-1:0];
    out_vertex.data.corner        = corner_r;
    out_vertex.data.quad_done     = (corner_r == CORNER_RIGHT);
    unique case (corner_r)
      CORNER_PEN: begin
        out_vertex.data.vertex_x = quad_r.x0;
        out_vertex.data.vertex_y = quad_r.y1;
        out_vertex.data.vertex_u = quad_r.tex.u0;
        out_vertex.data.vertex_v = quad_r.tex.v0;
      end
      CORNER_UP: begin
        out_vertex.data.vertex_x = quad_r.x0;
        out_vertex.data.vertex_y = quad_r.y0;
        out_vertex.data.vertex_u = quad_r.tex.u0;
        out_vertex.data.vertex_v = quad_r.tex.v1;
      end
      CORNER_UP_RIGHT: begin
        out_vertex.data.vertex_x = quad_r.x1;
        out_vertex.data.vertex_y = quad_r.y0;
        out_vertex.data.vertex_u = quad_r.tex.u1;
        out_vertex.data.vertex_v = quad_r.tex.v1;
      end
      default: begin
        out_vertex.data.vertex_x = quad_r.x1;
        out_vertex.data.vertex_y = quad_r.y1;
        out_vertex.data.vertex_u = quad_r.tex.u1;
        out_vertex.data.vertex_v = quad_r.tex.v0;
      end
    endcase
  end

  assign out_vertex.valid = quad_valid_r;

  `GQG_ASSERT_NEXT(a_quad_not_broken, clk, rst_n, xfer && corner_r != CORNER_RIGHT, quad_valid_r)
  `GQG_ASSERT_NEXT(a_load_starts_at_pen, clk, rst_n, load, quad_valid_r && corner_r == CORNER_PEN)
  `GQG_ASSERT_NEXT(a_number_steps, clk, rst_n, xfer && corner_r != CORNER_RIGHT, num_w == $past(num_w) + INDEX_BITS'(1))

endmodule
`default_nettype wire

FILE: rtl/glyph_quad_generator.sv
// Top level of the glyph quad generator: registers, input stage and pipeline.
//
// Usage: glyphs arrive on in_glyph, one per transfer, with their font metrics
// and texture rectangle. Each visible glyph leaves as four vertex transfers on
// out_vertex (corners pen, up, up-right, right), the last one with quad_done
// set. Newlines and glyphs outside the scissor produce no vertices but still
// move the pen; carriage returns produce none and leave the pen where it is.
// Registers are written through cfg_wr, which is always ready, and must only
// change while the block is idle. An input transfer reaches its first vertex
// through the input register, the scaling register and the quad register,
// with placement done in the logic in front of the quad register. A visible
// glyph occupies the quad register until its four vertices are taken, so
// visible text is paced by the single vertex output port; glyphs without
// vertices pass at one per cycle when no visible glyph ahead of them waits.
// Reset restores the register defaults, clears the pen and the vertex index,
// and makes the next glyph start from the origin. When the receiver stalls,
// the current vertex holds and the pipeline fills and then drops in_ready.
`default_nettype none
module glyph_quad_generator import gqg_pkg::*; #(
  parameter int SUBPIXEL_BITS = 4,
  parameter int INDEX_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  gqg_cfg_if.sink      cfg_wr,
  gqg_glyph_if.sink    in_glyph,
  gqg_vertex_if.source out_vertex
);

  localparam int SCALED_W = PROD_W - (SCALE_FRAC - SUBPIXEL_BITS);

  cfg_t   cfg_r, cfg_nxt;
  logic   in_valid_r, in_valid_nxt;
  glyph_t in_data_r;
  logic   in_load;

  logic                       scale_ready;
  logic                       s_valid, s_ready;
  logic signed [SCALED_W-1:0] s_off_x, s_off_y, s_size_x, s_size_y, s_adv;
  item_ctl_t                  s_ctl;
  tex_t                       s_tex;

  logic                  p_valid, p_ready;
  quad_t                 p_quad;
  logic [INDEX_BITS-1:0] p_base;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_ORIGIN_X:     cfg_nxt.origin_x     = cfg_wr.data[ORIGIN_W-1:0];
        REG_ORIGIN_Y:     cfg_nxt.origin_y     = cfg_wr.data[ORIGIN_W-1:0];
        REG_LINE_SPACING: cfg_nxt.line_spacing = cfg_wr.data[SPACING_W-1:0];
        REG_GLYPH_SCALE:  cfg_nxt.glyph_scale  = cfg_wr.data[SCALE_W-1:0];
        REG_CLIP_LEFT:    cfg_nxt.clip_left    = cfg_wr.data[COORD_W-1:0];
        REG_CLIP_TOP:     cfg_nxt.clip_top     = cfg_wr.data[COORD_W-1:0];
        REG_CLIP_RIGHT:   cfg_nxt.clip_right   = cfg_wr.data[COORD_W-1:0];
        REG_CLIP_BOTTOM:  cfg_nxt.clip_bottom  = cfg_wr.data[COORD_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.line_spacing <= 10'd16;
      cfg_r.glyph_scale  <= 16'd4096;
      cfg_r.clip_left    <= '0;
      cfg_r.clip_top     <= '0;
      cfg_r.clip_right   <= COORD_MAX;
      cfg_r.clip_bottom  <= COORD_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_glyph.ready = !in_valid_r || scale_ready;
  assign in_load        = in_glyph.valid && in_glyph.ready;
  assign in_valid_nxt   = in_glyph.ready ? in_glyph.valid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_data_r <= in_glyph.data;
    end
  end

  gqg_scale #(
    .SUBPIXEL_BITS(SUBPIXEL_BITS)
  ) u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .glyph_scale (cfg_r.glyph_scale),
    .up_valid    (in_valid_r),
    .up_ready    (scale_ready),
    .glyph       (in_data_r),
    .dn_valid    (s_valid),
    .dn_ready    (s_ready),
    .off_x       (s_off_x),
    .off_y       (s_off_y),
    .size_x      (s_size_x),
    .size_y      (s_size_y),
    .adv         (s_adv),
    .ctl         (s_ctl),
    .tex         (s_tex)
  );

  gqg_place #(
    .SUBPIXEL_BITS(SUBPIXEL_BITS),
    .INDEX_BITS   (INDEX_BITS)
  ) u_place (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .up_valid    (s_valid),
    .up_ready    (s_ready),
    .off_x       (s_off_x),
    .off_y       (s_off_y),
    .size_x      (s_size_x),
    .size_y      (s_size_y),
    .adv         (s_adv),
    .ctl         (s_ctl),
    .tex         (s_tex),
    .dn_valid    (p_valid),
    .dn_ready    (p_ready),
    .quad        (p_quad),
    .number_base (p_base)
  );

  gqg_emit #(
    .INDEX_BITS(INDEX_BITS)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (p_valid),
    .up_ready    (p_ready),
    .quad        (p_quad),
    .number_base (p_base),
    .out_vertex  (out_vertex)
  );

endmodule
`default_nettype wire

FILE: sim/glyph_quad_checker.sv
// Checker for the glyph quad generator: predicts the vertices of each glyph transfer.
`timescale 1ns / 1ps
module glyph_quad_checker import gqg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  gqg_cfg_if    cfg_bus,
  gqg_glyph_if  glyph_bus,
  gqg_vertex_if vertex_bus,
  output int    error_count,
  output int    vertices_owed
);

  localparam int SUBPIXEL_BITS = 4;
  localparam int ROUND_SHIFT = SCALE_FRAC - SUBPIXEL_BITS;
  localparam int PRINT_CAP = 40;

  cfg_t                layout_regs;
  longint              pen_column;
  longint              pen_row;
  logic [NUMBER_W-1:0] vertex_counter;
  bit                  restart_pending;
  vertex_t             expected_vertices[$];

  task automatic report_failure(input string msg);
    if (error_count < PRINT_CAP) begin
      $display("[%0t] %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic longint clamp_coord(input longint v);
    if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
    if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
    return v;
  endfunction

  // Font pixels to subpixel units, scaled, rounded half toward plus infinity.
  function automatic longint scale_font(input longint n);
    longint factor;
    factor = layout_regs.glyph_scale;
    return (n * factor + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
  endfunction

  function automatic longint origin_column();
    longint o;
    o = $signed(layout_regs.origin_x);
    return clamp_coord(o <<< SUBPIXEL_BITS);
  endfunction

  task automatic push_vertex(input longint x, input longint y, input logic [TEX_W-1:0] u,
                             input logic [TEX_W-1:0] v, input corner_t c);
    vertex_t vx;
    vx.vertex_x = COORD_W'(clamp_coord(x));
    vx.vertex_y = COORD_W'(clamp_coord(y));
    vx.vertex_u = u;
    vx.vertex_v = v;
    vx.vertex_number = vertex_counter;
    vx.corner = c;
    vx.quad_done = (c == CORNER_RIGHT);
    vertex_counter = vertex_counter + 1'b1;
    expected_vertices = {expected_vertices, vx};
  endtask

  task automatic place_glyph(input glyph_t g);
    longint px, py, sx, sy, spacing, oy;
    longint cl, ct, cr, cb;
    if (restart_pending) begin
      oy = $signed(layout_regs.origin_y);
      pen_column = origin_column();
      pen_row = clamp_coord(oy <<< SUBPIXEL_BITS);
      restart_pending = 1'b0;
    end
    if (g.code_point == CODE_NEWLINE) begin
      spacing = layout_regs.line_spacing;
      pen_row = clamp_coord(pen_row + (spacing <<< SUBPIXEL_BITS));
      pen_column = origin_column();
    end else if (g.code_point != CODE_RETURN) begin
      px = pen_column + scale_font($signed(g.offset_x));
      py = pen_row + scale_font($signed(g.offset_y));
      sx = scale_font(g.glyph_width);
      sy = scale_font(g.glyph_height);
      cl = $signed(layout_regs.clip_left);
      ct = $signed(layout_regs.clip_top);
      cr = $signed(layout_regs.clip_right);
      cb = $signed(layout_regs.clip_bottom);
      if (px < cr && px + sx > cl && py - sy < cb && py > ct) begin
        push_vertex(px, py, g.tex_u0, g.tex_v0, CORNER_PEN);
        push_vertex(px, py - sy, g.tex_u0, g.tex_v1, CORNER_UP);
        push_vertex(px + sx, py - sy, g.tex_u1, g.tex_v1, CORNER_UP_RIGHT);
        push_vertex(px + sx, py, g.tex_u1, g.tex_v0, CORNER_RIGHT);
      end
      pen_column = clamp_coord(pen_column + scale_font(g.advance));
    end
    if (g.last_glyph) begin
      restart_pending = 1'b1;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input logic [NUMBER_W-1:0] number);
    if (got !== want) begin
      report_failure($sformatf("vertex %0d: %s is %0h, expected %0h", number, name, got, want));
    end
  endtask

  task automatic check_vertex(input vertex_t got);
    vertex_t want;
    if (expected_vertices.size() == 0) begin
      report_failure($sformatf("vertex %0h arrived with no glyph pending", got.vertex_number));
      return;
    end
    want = expected_vertices.pop_front();
    compare_field("vertex_x", got.vertex_x, want.vertex_x, want.vertex_number);
    compare_field("vertex_y", got.vertex_y, want.vertex_y, want.vertex_number);
    compare_field("vertex_u", got.vertex_u, want.vertex_u, want.vertex_number);
    compare_field("vertex_v", got.vertex_v, want.vertex_v, want.vertex_number);
    compare_field("vertex_number", got.vertex_number, want.vertex_number, want.vertex_number);
    compare_field("corner", got.corner, want.corner, want.vertex_number);
    compare_field("quad_done", got.quad_done, want.quad_done, want.vertex_number);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      layout_regs.origin_x = '0;
      layout_regs.origin_y = '0;
      layout_regs.line_spacing = SPACING_W'(16);
      layout_regs.glyph_scale = SCALE_W'(4096);
      layout_regs.clip_left = '0;
      layout_regs.clip_top = '0;
      layout_regs.clip_right = COORD_MAX;
      layout_regs.clip_bottom = COORD_MAX;
      pen_column = 0;
      pen_row = 0;
      vertex_counter = '0;
      restart_pending = 1'b1;
      expected_vertices.delete();
      error_count = 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_ORIGIN_X:     layout_regs.origin_x = cfg_bus.data[ORIGIN_W-1:0];
          REG_ORIGIN_Y:     layout_regs.origin_y = cfg_bus.data[ORIGIN_W-1:0];
          REG_LINE_SPACING: layout_regs.line_spacing = cfg_bus.data[SPACING_W-1:0];
          REG_GLYPH_SCALE:  layout_regs.glyph_scale = cfg_bus.data[SCALE_W-1:0];
          REG_CLIP_LEFT:    layout_regs.clip_left = cfg_bus.data[COORD_W-1:0];
          REG_CLIP_TOP:     layout_regs.clip_top = cfg_bus.data[COORD_W-1:0];
          REG_CLIP_RIGHT:   layout_regs.clip_right = cfg_bus.data[COORD_W-1:0];
          REG_CLIP_BOTTOM:  layout_regs.clip_bottom = cfg_bus.data[COORD_W-1:0];
          default: ;
        endcase
      end
      if (vertex_bus.valid && vertex_bus.ready) begin
        check_vertex(vertex_bus.data);
      end
      if (glyph_bus.valid && glyph_bus.ready) begin
        place_glyph(glyph_bus.data);
      end
    end
    vertices_owed = expected_vertices.size();
  end

endmodule

FILE: sim/glyph_quad_generator_tb.sv
// Testbench top for the glyph quad generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module glyph_quad_generator_tb;
  import gqg_pkg::*;

  localparam logic [CODE_W-1:0] CODE_TAB = 21'd9;
  localparam int CYCLE_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS = 85;
  localparam int GLYPH_BITS = $bits(glyph_t);

  logic clk;
  logic rst_n;
  int   error_count;
  int   vertices_owed;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   hold_left = 0;
  int   cycle_count = 0;

  gqg_cfg_if    cfg_ch ();
  gqg_glyph_if  glyph_ch ();
  gqg_vertex_if vertex_ch ();

  glyph_quad_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_ch),
    .in_glyph   (glyph_ch),
    .out_vertex (vertex_ch)
  );

  glyph_quad_checker layout_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_bus       (cfg_ch),
    .glyph_bus     (glyph_ch),
    .vertex_bus    (vertex_ch),
    .error_count   (error_count),
    .vertices_owed (vertices_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("glyph_quad_generator_tb: errors");
    $finish;
  end

  // The receiver either sits out a requested hold-off or stalls at random.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        vertex_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        vertex_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  task automatic send_glyph(input glyph_t g);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      glyph_ch.valid <= 1'b0;
      @(negedge clk);
    end
    glyph_ch.valid <= 1'b1;
    glyph_ch.data <= g;
    @(posedge clk);
    while (!glyph_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic quiesce();
    glyph_ch.valid <= 1'b0;
    while (vertices_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    write_register(REG_ORIGIN_X, {{4{s.origin_x[ORIGIN_W-1]}}, s.origin_x});
    write_register(REG_ORIGIN_Y, {{4{s.origin_y[ORIGIN_W-1]}}, s.origin_y});
    write_register(REG_LINE_SPACING, {10'd0, s.line_spacing});
    write_register(REG_GLYPH_SCALE, {4'd0, s.glyph_scale});
    write_register(REG_CLIP_LEFT, s.clip_left);
    write_register(REG_CLIP_TOP, s.clip_top);
    write_register(REG_CLIP_RIGHT, s.clip_right);
    write_register(REG_CLIP_BOTTOM, s.clip_bottom);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic cfg_t make_settings(input int ox, input int oy, input int spacing,
                                         input int scale, input int left, input int top,
                                         input int right, input int bottom);
    cfg_t s;
    s.origin_x = ORIGIN_W'(ox);
    s.origin_y = ORIGIN_W'(oy);
    s.line_spacing = SPACING_W'(spacing);
    s.glyph_scale = SCALE_W'(scale);
    s.clip_left = COORD_W'(left);
    s.clip_top = COORD_W'(top);
    s.clip_right = COORD_W'(right);
    s.clip_bottom = COORD_W'(bottom);
    return s;
  endfunction

  function automatic cfg_t random_settings(input int flavor);
    cfg_t s;
    s = make_settings($urandom_range(200), $urandom_range(400, 40), $urandom_range(40, 8),
                      $urandom_range(8192, 2048), 0, 0, COORD_MAX, COORD_MAX);
    case (flavor)
      1: begin
        s.origin_x = ORIGIN_W'($urandom);
        s.origin_y = ORIGIN_W'($urandom);
        s.line_spacing = SPACING_W'($urandom);
        s.glyph_scale = SCALE_W'($urandom);
        s.clip_left = COORD_MIN;
        s.clip_top = COORD_MIN;
      end
      2: begin
        s.clip_left = COORD_W'($urandom_range(3000));
        s.clip_top = COORD_W'($urandom_range(3000));
        s.clip_right = s.clip_left + COORD_W'($urandom_range(4000));
        s.clip_bottom = s.clip_top + COORD_W'($urandom_range(4000));
      end
      3: begin
        s.glyph_scale = SCALE_W'($urandom_range(65535, 40000));
        s.line_spacing = SPACING_W'($urandom_range(1023, 900));
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic glyph_t make_glyph(input logic [CODE_W-1:0] code, input int offx,
                                        input int offy, input int w, input int h,
                                        input int adv, input bit last);
    glyph_t g;
    g.code_point = code;
    g.offset_x = OFFSET_W'(offx);
    g.offset_y = OFFSET_W'(offy);
    g.glyph_width = SIZE_W'(w);
    g.glyph_height = SIZE_W'(h);
    g.advance = SIZE_W'(adv);
    g.tex_u0 = TEX_W'($urandom);
    g.tex_v0 = TEX_W'($urandom);
    g.tex_u1 = TEX_W'($urandom);
    g.tex_v1 = TEX_W'($urandom);
    g.last_glyph = last;
    return g;
  endfunction

  function automatic glyph_t text_glyph();
    return make_glyph(CODE_W'($urandom_range('h10FFFF, 32)), int'($urandom_range(64)) - 32,
                      int'($urandom_range(64)) - 32, $urandom_range(80),
                      $urandom_range(80), $urandom_range(80), 1'b0);
  endfunction

  function automatic glyph_t noise_glyph();
    logic [GLYPH_BITS-1:0] raw;
    raw = GLYPH_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return glyph_t'(raw);
  endfunction

  // Mostly whole lines of text that end with a last glyph, some broken sequences of noise.
  task automatic run_text(input int count);
    int     sent;
    int     len;
    int     k;
    int     pick;
    bit     broken;
    glyph_t g;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(12, 2);
      broken = ($urandom_range(99) < 15);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(99);
        if (broken) begin
          g = noise_glyph();
        end else if (pick < 8) begin
          g = noise_glyph();
          g.code_point = CODE_NEWLINE;
        end else if (pick < 12) begin
          g = noise_glyph();
          g.code_point = CODE_RETURN;
        end else if (pick < 16) begin
          g = text_glyph();
          g.code_point = CODE_TAB;
        end else begin
          g = text_glyph();
        end
        if (!broken) begin
          g.last_glyph = (k == len - 1);
        end
        send_glyph(g);
        sent++;
      end
    end
  endtask

  task automatic run_directed();
    glyph_t g;
    g = make_glyph(21'd65, 1, 2, 8, 10, 9, 1'b0);
    g.tex_u0 = '0;
    g.tex_v0 = '0;
    g.tex_u1 = '0;
    g.tex_v1 = '0;
    send_glyph(g);
    g = make_glyph(21'd0, 0, 0, 0, 0, 0, 1'b0);
    g.tex_u0 = '1;
    g.tex_v0 = '1;
    g.tex_u1 = '1;
    g.tex_v1 = '1;
    send_glyph(g);
    send_glyph(make_glyph(CODE_TAB, 0, 3, 4, 1, 16, 1'b0));
    send_glyph(make_glyph(CODE_NEWLINE, 5, 5, 5, 5, 5, 1'b0));
    send_glyph(make_glyph(CODE_RETURN, 7, 7, 7, 7, 7, 1'b0));
    send_glyph(make_glyph(21'h1FFFFF, -2048, 2047, 1023, 1023, 1023, 1'b0));
    send_glyph(make_glyph(21'd66, 2047, -2048, 1023, 1023, 1023, 1'b0));
    send_glyph(make_glyph(CODE_RETURN, 0, 0, 0, 0, 0, 1'b1));
    send_glyph(make_glyph(21'd67, 0, 4, 4, 4, 4, 1'b0));
    send_glyph(make_glyph(CODE_NEWLINE, 0, 0, 0, 0, 0, 1'b1));
    send_glyph(make_glyph(21'd68, 0, 4, 4, 4, 4, 1'b1));

    // Largest origin, spacing and scale: the pen saturates in both directions.
    quiesce();
    load_settings(make_settings(32767, 32767, 1023, 65535, COORD_MIN, COORD_MIN,
                                COORD_MAX, COORD_MAX));
    repeat (3) send_glyph(make_glyph(21'd69, 0, 0, 1023, 1023, 1023, 1'b0));
    send_glyph(make_glyph(CODE_NEWLINE, 0, 0, 0, 0, 0, 1'b0));
    send_glyph(make_glyph(21'd70, -2048, -2048, 1, 1, 0, 1'b1));

    // Smallest origin, zero spacing and scale, and an inverted scissor.
    quiesce();
    load_settings(make_settings(-32768, -32768, 0, 0, 1000, 1000, -1000, -1000));
    send_glyph(make_glyph(21'd71, 3, 3, 3, 3, 3, 1'b0));
    send_glyph(make_glyph(CODE_NEWLINE, 0, 0, 0, 0, 0, 1'b0));
    send_glyph(make_glyph(21'd72, 3, 3, 3, 3, 3, 1'b1));

    // Boxes that touch a scissor edge from outside do not overlap it; one inside does.
    quiesce();
    load_settings(make_settings(0, 0, 16, 4096, 0, 0, 160, 160));
    send_glyph(make_glyph(21'd73, -1, 1, 1, 1, 0, 1'b0));
    send_glyph(make_glyph(21'd74, 10, 1, 1, 1, 0, 1'b0));
    send_glyph(make_glyph(21'd75, 9, 1, 1, 1, 0, 1'b0));
    send_glyph(make_glyph(21'd76, 0, 0, 1, 0, 0, 1'b1));
  endtask

  initial begin
    int phase;
    rst_n = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    glyph_ch.valid = 1'b0;
    glyph_ch.data = '0;
    vertex_ch.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (phase = 0; phase < 4; phase++) begin
      quiesce();
      load_settings(random_settings(phase));
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 64;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 64;
        end
        default: begin
          sender_idle_pct = 30;
          receiver_stall_pct = 30;
        end
      endcase
      run_text(PHASE_ITEMS);
    end

    // The receiver holds off long enough for the block to fill and stall its input.
    quiesce();
    load_settings(random_settings(0));
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    run_text(40);

    quiesce();
    if (error_count == 0 && vertices_owed == 0) begin
      $display("glyph_quad_generator_tb: clean");
    end else begin
      $display("glyph_quad_generator_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/gqg_pkg.sv
rtl/gqg_channels.sv
rtl/gqg_scale.sv
rtl/gqg_place.sv
rtl/gqg_emit.sv
rtl/glyph_quad_generator.sv
sim/glyph_quad_checker.sv
sim/glyph_quad_generator_tb.sv
